@@ sv/assert_macros.svh @@
// Assertion macros shared by the frame time statistics RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define FTWS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent, outside reset.
`define FTWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/ftws_pkg.sv @@
// Shared widths, constants and types of the frame time statistics block.
`default_nettype none

package ftws_pkg;

  localparam int unsigned DATA_W            = 20;
  localparam int unsigned RATE_W            = 27;
  localparam int unsigned ACC_W             = 21;
  localparam int unsigned HISTORY_DEPTH_DEF = 128;
  localparam int unsigned QUEUE_DEPTH       = 4;
  localparam int unsigned QPTR_W            = $clog2(QUEUE_DEPTH);

  localparam logic [DATA_W-1:0] UPDATE_INTERVAL_RST = DATA_W'(500000);
  localparam logic [RATE_W-1:0] RATE_NUM            = RATE_W'(100000000);

  // One classified frame handed from the front end to the back end.
  typedef struct packed {
    logic [DATA_W-1:0] sample;
    logic              emit;
  } cmd_t;

endpackage

`default_nettype wire

@@ sv/ftws_if.sv @@
// Valid/ready channel interfaces for frames, statistics and configuration.
`default_nettype none

interface ftws_in_if;
  import ftws_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] frame_time_us;
  modport source (output valid, output frame_time_us, input ready);
  modport sink (input valid, input frame_time_us, output ready);
endinterface

interface ftws_out_if;
  import ftws_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] mean_us;
  logic [DATA_W-1:0] min_us;
  logic [DATA_W-1:0] max_us;
  logic [RATE_W-1:0] rate_centi_fps;
  modport source (output valid, output mean_us, output min_us, output max_us,
                  output rate_centi_fps, input ready);
  modport sink (input valid, input mean_us, input min_us, input max_us,
                input rate_centi_fps, output ready);
endinterface

interface ftws_cfg_if;
  import ftws_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] update_interval_us;
  modport source (output valid, output update_interval_us, input ready);
  modport sink (input valid, input update_interval_us, output ready);
endinterface

`default_nettype wire

@@ sv/ftws_front.sv @@
// Front end: takes frames, runs the interval accumulator and tags update frames.
`default_nettype none

module ftws_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  ftws_in_if.sink         in_i,
  ftws_cfg_if.sink        cfg_i,
  output logic            push_valid_o,
  input  logic            push_ready_i,
  output ftws_pkg::cmd_t  push_cmd_o
);
  import ftws_pkg::*;

  logic [DATA_W-1:0] interval_q;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [ACC_W-1:0]  acc_sum;
  logic              hit;
  logic              accept;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = push_ready_i;
  assign accept      = in_i.valid && push_ready_i;

  // The frame that reaches the interval is part of the update it triggers.
  assign acc_sum = acc_q + ACC_W'(in_i.frame_time_us);
  assign hit     = acc_sum >= ACC_W'(interval_q);

  assign push_valid_o      = in_i.valid;
  assign push_cmd_o.sample = in_i.frame_time_us;
  assign push_cmd_o.emit   = hit;

  always_comb begin
    acc_d = acc_q;
    if (accept) begin
      acc_d = hit ? '0 : acc_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= UPDATE_INTERVAL_RST;
      acc_q      <= '0;
    end else begin
      acc_q <= acc_d;
      if (cfg_i.valid) begin
        interval_q <= cfg_i.update_interval_us;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/ftws_fifo.sv @@
// Small command queue between the front end and the back end.
`default_nettype none
`include "assert_macros.svh"

module ftws_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  ftws_pkg::cmd_t push_cmd_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output ftws_pkg::cmd_t pop_cmd_o
);
  import ftws_pkg::*;

  cmd_t              entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = cnt_q != (QPTR_W + 1)'(QUEUE_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_cmd_o    = entries_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  `FTWS_ASSERT(a_cnt_bound, cnt_q <= (QPTR_W + 1)'(QUEUE_DEPTH), "queue count beyond depth")
  `FTWS_ASSERT(a_ptr_match, (cnt_q == '0 || cnt_q == (QPTR_W + 1)'(QUEUE_DEPTH)) |-> wr_ptr_q == rd_ptr_q, "queue pointers disagree with count")
  `FTWS_ASSERT_NEXT(a_cnt_inc, push && !pop, cnt_q == $past(cnt_q) + 1'b1, "queue count missed a push")

endmodule

`default_nettype wire

@@ sv/ftws_div.sv @@
// Restoring divider that retires one quotient bit per cycle.
`default_nettype none

module ftws_div #(
  parameter int unsigned N_W = ftws_pkg::RATE_W,
  parameter int unsigned D_W = ftws_pkg::DATA_W
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [N_W-1:0] dividend_i,
  input  logic [D_W-1:0] divisor_i,
  output logic           done_o,
  output logic [N_W-1:0] quot_o
);
  import ftws_pkg::*;

  localparam int unsigned CW = $clog2(N_W + 1);

  logic           busy_q, busy_d;
  logic           done_q, done_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [D_W-1:0] rem_q, rem_d;
  logic [D_W-1:0] dvs_q, dvs_d;
  logic [N_W-1:0] quot_q, quot_d;
  logic [D_W:0]   trial;
  logic           ge;

  // The partial remainder stays below the divisor, so D_W+1 bits hold the trial.
  assign trial = {rem_q, quot_q[N_W-1]} - {1'b0, dvs_q};
  assign ge    = !trial[D_W];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(N_W);
      rem_d  = '0;
      dvs_d  = divisor_i;
      quot_d = dividend_i;
    end else if (busy_q) begin
      rem_d  = ge ? trial[D_W-1:0] : {rem_q[D_W-2:0], quot_q[N_W-1]};
      quot_d = {quot_q[N_W-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      quot_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      rem_q  <= rem_d;
      dvs_q  <= dvs_d;
      quot_q <= quot_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

@@ sv/ftws_back.sv @@
// Back end: history ring, window walk for sum/min/max, and the mean and (for a nonzero mean) rate divisions.
`default_nettype none
`include "assert_macros.svh"

module ftws_back #(
  parameter int unsigned HISTORY_DEPTH = ftws_pkg::HISTORY_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  ftws_pkg::cmd_t cmd_i,
  ftws_out_if.source     out_o
);
  import ftws_pkg::*;

  localparam int unsigned PTR_W   = $clog2(HISTORY_DEPTH);
  localparam int unsigned CNT_W   = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned SUM_W   = DATA_W + CNT_W;
  localparam int unsigned DIV_N_W = (SUM_W > RATE_W) ? SUM_W : RATE_W;
  localparam int unsigned DIV_D_W = (CNT_W > DATA_W) ? CNT_W : DATA_W;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(HISTORY_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(HISTORY_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_RATE_GO,
    ST_RATE_WAIT,
    ST_OUT
  } state_e;

  state_e            state_q, state_d;
  logic [PTR_W-1:0]  wp_q, wp_d;
  logic [CNT_W-1:0]  vcnt_q, vcnt_d;
  logic [CNT_W-1:0]  vcnt_inc;
  logic [CNT_W-1:0]  n_q, n_d;
  logic [CNT_W-1:0]  rd_idx_q, rd_idx_d;
  logic              rd_vld_q, rd_vld_d;
  logic              first_q, first_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [DATA_W-1:0] lo_q, lo_d;
  logic [DATA_W-1:0] hi_q, hi_d;
  logic [DATA_W-1:0] mean_q, mean_d;
  logic [RATE_W-1:0] rate_q, rate_d;
  logic              out_vld_q, out_vld_d;

  logic [DATA_W-1:0] hist_q [HISTORY_DEPTH];
  logic [DATA_W-1:0] rd_data_q;
  logic [PTR_W-1:0]  rd_addr;
  logic              wr_en, rd_en;

  logic               div_start, div_done;
  logic [DIV_N_W-1:0] div_dividend, div_quot;
  logic [DIV_D_W-1:0] div_divisor;

  ftws_div #(
    .N_W(DIV_N_W),
    .D_W(DIV_D_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  assign cmd_ready_o = state_q == ST_IDLE;
  assign rd_addr     = rd_idx_q[PTR_W-1:0];
  assign vcnt_inc    = (vcnt_q == FULL_CNT) ? vcnt_q : vcnt_q + 1'b1;

  always_comb begin
    state_d      = state_q;
    wp_d         = wp_q;
    vcnt_d       = vcnt_q;
    n_d          = n_q;
    rd_idx_d     = rd_idx_q;
    rd_vld_d     = rd_vld_q;
    first_d      = first_q;
    sum_d        = sum_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    mean_d       = mean_q;
    rate_d       = rate_q;
    out_vld_d    = out_vld_q;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          wr_en  = 1'b1;
          wp_d   = (wp_q == LAST_PTR) ? '0 : wp_q + 1'b1;
          vcnt_d = vcnt_inc;
          if (cmd_i.emit) begin
            n_d      = vcnt_inc;
            rd_idx_d = '0;
            rd_vld_d = 1'b0;
            first_d  = 1'b1;
            sum_d    = '0;
            state_d  = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        // Reads are issued one per cycle; the data lands in the cycle after each read.
        rd_vld_d = 1'b0;
        if (rd_idx_q != n_q) begin
          rd_en    = 1'b1;
          rd_vld_d = 1'b1;
          rd_idx_d = rd_idx_q + 1'b1;
        end
        if (rd_vld_q) begin
          first_d = 1'b0;
          sum_d   = sum_q + SUM_W'(rd_data_q);
          lo_d    = (first_q || rd_data_q < lo_q) ? rd_data_q : lo_q;
          hi_d    = (first_q || rd_data_q > hi_q) ? rd_data_q : hi_q;
          if (rd_idx_q == n_q) begin
            state_d = ST_MEAN_GO;
          end
        end
      end
      ST_MEAN_GO: begin
        div_start    = 1'b1;
        div_dividend = DIV_N_W'(sum_q);
        div_divisor  = DIV_D_W'(n_q);
        state_d      = ST_MEAN_WAIT;
      end
      ST_MEAN_WAIT: begin
        if (div_done) begin
          mean_d = div_quot[DATA_W-1:0];
          if (div_quot[DATA_W-1:0] == '0) begin
            rate_d    = '0;
            out_vld_d = 1'b1;
            state_d   = ST_OUT;
          end else begin
            state_d = ST_RATE_GO;
          end
        end
      end
      ST_RATE_GO: begin
        div_start    = 1'b1;
        div_dividend = DIV_N_W'(RATE_NUM);
        div_divisor  = DIV_D_W'(mean_q);
        state_d      = ST_RATE_WAIT;
      end
      ST_RATE_WAIT: begin
        if (div_done) begin
          rate_d    = div_quot[RATE_W-1:0];
          out_vld_d = 1'b1;
          state_d   = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_o.ready) begin
          out_vld_d = 1'b0;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      wp_q      <= '0;
      vcnt_q    <= '0;
      n_q       <= '0;
      rd_idx_q  <= '0;
      rd_vld_q  <= 1'b0;
      first_q   <= 1'b0;
      sum_q     <= '0;
      lo_q      <= '0;
      hi_q      <= '0;
      mean_q    <= '0;
      rate_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wp_q      <= wp_d;
      vcnt_q    <= vcnt_d;
      n_q       <= n_d;
      rd_idx_q  <= rd_idx_d;
      rd_vld_q  <= rd_vld_d;
      first_q   <= first_d;
      sum_q     <= sum_d;
      lo_q      <= lo_d;
      hi_q      <= hi_d;
      mean_q    <= mean_d;
      rate_q    <= rate_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hist_q[wp_q] <= cmd_i.sample;
    end
    if (rd_en) begin
      rd_data_q <= hist_q[rd_addr];
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.mean_us        = mean_q;
  assign out_o.min_us         = lo_q;
  assign out_o.max_us         = hi_q;
  assign out_o.rate_centi_fps = rate_q;

  `FTWS_ASSERT(a_vcnt_bound, vcnt_q <= FULL_CNT, "valid count beyond history depth")
  `FTWS_ASSERT(a_walk_bound, state_q == ST_WALK |-> rd_idx_q <= n_q, "history walk ran past the valid count")
  `FTWS_ASSERT_NEXT(a_walk_nonempty, state_q == ST_IDLE && cmd_valid_i && cmd_i.emit, n_q != '0, "update started with an empty window")

endmodule

`default_nettype wire

@@ sv/frame_time_window_stats.sv @@
// Top level of the frame time window statistics block.
`default_nettype none

// Frame time statistics over the last HISTORY_DEPTH frames. Each item on in_i
// is one frame time in microseconds; once the frame times summed since the
// last update reach update_interval_us, one item leaves on out_o with the
// truncated mean, the minimum, the maximum and the frame rate in hundredths
// of a frame per second, the triggering frame included. Frames enter a
// four-entry queue and are retired one per cycle when no update is pending.
// An update frame occupies the back end while the window of stored frames (up
// to HISTORY_DEPTH of them) is read through one memory read port one entry
// per cycle and then while the mean and, unless the mean is zero, the rate
// come out of the shared bit-serial divider one bit per cycle; the divider is
// W bits wide (28 at the default depth). The configuration register is
// written through cfg_i, which is always ready.
module frame_time_window_stats #(
  parameter int unsigned HISTORY_DEPTH = ftws_pkg::HISTORY_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ftws_in_if.sink    in_i,
  ftws_cfg_if.sink   cfg_i,
  ftws_out_if.source out_o
);
  import ftws_pkg::*;

  logic push_valid, push_ready;
  logic pop_valid, pop_ready;
  cmd_t push_cmd, pop_cmd;

  ftws_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_cmd_o  (push_cmd)
  );

  ftws_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_cmd_i  (push_cmd),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_cmd_o   (pop_cmd)
  );

  ftws_back #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(pop_valid),
    .cmd_ready_o(pop_ready),
    .cmd_i      (pop_cmd),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire

@@ dv/tb_frame_time_window_stats.sv @@
// Self-checking testbench of frame_time_window_stats: directed and random frame times.
`timescale 1ns / 1ps

module tb_frame_time_window_stats;
  import ftws_pkg::*;

  localparam int unsigned HIST_DEPTH    = HISTORY_DEPTH_DEF;
  localparam int unsigned CENTI_FPS_NUM = 100_000_000;
  // Cycles to let the block settle after the last result, about one update.
  localparam int unsigned SETTLE_CYCLES = 256;
  localparam int unsigned LONG_HOLD     = 1500;

  typedef struct packed {
    logic [DATA_W-1:0] mean_us;
    logic [DATA_W-1:0] min_us;
    logic [DATA_W-1:0] max_us;
    logic [RATE_W-1:0] rate_centi_fps;
  } stats_t;

  typedef enum logic {ROW_FRAME, ROW_INTERVAL} row_op_e;
  typedef enum logic [1:0] {CHK_MODEL, CHK_QUIET, CHK_TYPED} row_chk_e;
  typedef enum logic [1:0] {STYLE_TINY, STYLE_MIXED, STYLE_STEADY} frame_style_e;

  typedef struct packed {
    row_op_e           op;
    logic [DATA_W-1:0] value;
    row_chk_e          chk;
    stats_t            typed;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 19;

  // The first rows run with the interval left at its reset value.
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_FRAME,    20'd0,       CHK_QUIET, '0},
    '{ROW_FRAME,    20'd500000,  CHK_TYPED, '{20'd250000, 20'd0, 20'd500000, 27'd400}},
    '{ROW_FRAME,    20'hFFFFF,   CHK_MODEL, '0},
    '{ROW_FRAME,    20'd499999,  CHK_QUIET, '0},
    '{ROW_FRAME,    20'd1,       CHK_MODEL, '0},
    '{ROW_INTERVAL, 20'd0,       CHK_MODEL, '0},
    '{ROW_FRAME,    20'd0,       CHK_MODEL, '0},
    '{ROW_FRAME,    20'hFFFFF,   CHK_MODEL, '0},
    '{ROW_INTERVAL, 20'd1,       CHK_MODEL, '0},
    '{ROW_FRAME,    20'd0,       CHK_QUIET, '0},
    '{ROW_FRAME,    20'd1,       CHK_MODEL, '0},
    '{ROW_INTERVAL, 20'hFFFFF,   CHK_MODEL, '0},
    '{ROW_FRAME,    20'hFFFFF,   CHK_MODEL, '0},
    '{ROW_FRAME,    20'd524288,  CHK_QUIET, '0},
    '{ROW_FRAME,    20'd524287,  CHK_MODEL, '0},
    '{ROW_FRAME,    20'h55555,   CHK_QUIET, '0},
    '{ROW_FRAME,    20'hAAAAA,   CHK_MODEL, '0},
    '{ROW_INTERVAL, 20'd1000000, CHK_MODEL, '0},
    '{ROW_FRAME,    20'd1000000, CHK_MODEL, '0}
  };

  logic clk_i;
  logic rst_ni;

  ftws_in_if  in_if ();
  ftws_cfg_if cfg_if ();
  ftws_out_if out_if ();

  frame_time_window_stats dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  // Window state as the block should hold it.
  logic [DATA_W-1:0] win_ring [HIST_DEPTH];
  int unsigned       win_wr_ptr = 0;
  int unsigned       win_fill = 0;
  logic [ACC_W-1:0]  win_accum = '0;
  logic [DATA_W-1:0] win_interval = UPDATE_INTERVAL_RST;

  stats_t      pending_stats [$];
  int unsigned mismatch_count = 0;
  bit          idle_off = 1'b0;
  int unsigned hold_reqs = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Adds one frame to the window; returns 1 with the statistics when an update fires.
  function automatic bit update_window(input logic [DATA_W-1:0] frame, output stats_t s);
    logic [63:0]       total;
    logic [63:0]       mean;
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
    s = '0;
    win_ring[win_wr_ptr] = frame;
    win_wr_ptr = (win_wr_ptr + 1) % HIST_DEPTH;
    if (win_fill < HIST_DEPTH) win_fill++;
    win_accum = win_accum + ACC_W'(frame);
    if (win_accum < ACC_W'(win_interval)) return 1'b0;
    win_accum = '0;
    total = '0;
    lo = win_ring[0];
    hi = win_ring[0];
    for (int unsigned i = 0; i < win_fill; i++) begin
      total += 64'(win_ring[i]);
      if (win_ring[i] < lo) lo = win_ring[i];
      if (win_ring[i] > hi) hi = win_ring[i];
    end
    mean = total / 64'(win_fill);
    s.mean_us = DATA_W'(mean);
    s.min_us  = lo;
    s.max_us  = hi;
    s.rate_centi_fps = (mean == 0) ? '0 : RATE_W'(64'(CENTI_FPS_NUM) / mean);
    return 1'b1;
  endfunction

  function automatic logic [DATA_W-1:0] pick_frame(input frame_style_e style);
    case (style)
      STYLE_TINY:   return DATA_W'($urandom_range(0, 2));
      STYLE_STEADY: return DATA_W'($urandom_range(15000, 18500));
      default: begin
        case ($urandom_range(0, 9))
          0:       return '0;
          1:       return '1;
          2:       return DATA_W'(1000000);
          3:       return DATA_W'($urandom_range(0, 15));
          4, 5, 6: return DATA_W'($urandom_range(1000, 100000));
          default: return DATA_W'($urandom_range(0, 20'hFFFFF));
        endcase
      end
    endcase
  endfunction

  task automatic sender_gap();
    if (!idle_off && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  task automatic send_frame(input logic [DATA_W-1:0] frame, input row_chk_e chk,
                            input stats_t typed);
    stats_t s;
    bit     fires;
    in_if.valid         <= 1'b1;
    in_if.frame_time_us <= frame;
    do @(posedge clk_i); while (!in_if.ready);
    fires = update_window(frame, s);
    case (chk)
      CHK_MODEL: if (fires) pending_stats.push_back(s);
      CHK_TYPED: pending_stats.push_back(typed);
      default: ;
    endcase
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk_i);
  endtask

  // The block must be idle: a frame that caused no result may still be queued.
  task automatic write_interval(input logic [DATA_W-1:0] value);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_if.valid              <= 1'b1;
    cfg_if.update_interval_us <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    win_interval = value;
  endtask

  task automatic run_phase(input logic [DATA_W-1:0] interval, input int unsigned items,
                           input frame_style_e style, input bit long_hold,
                           input bit drain_midway);
    write_interval(interval);
    if (long_hold) hold_reqs <= hold_reqs + 1;
    for (int unsigned k = 0; k < items; k++) begin
      if (drain_midway && k == items / 2) drain_results();
      sender_gap();
      send_frame(pick_frame(style), CHK_MODEL, '0);
    end
  endtask

  // Result side: random stall bursts, plus one long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_reqs != hold_seen) begin
      hold_seen    <= hold_reqs;
      hold_left    <= LONG_HOLD;
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      out_if.ready <= 1'b0;
    end else if (!idle_off && $urandom_range(0, 5) == 0) begin
      stall_left   <= $urandom_range(0, 6);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    stats_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_stats.size() == 0) begin
        report_mismatch("result with none expected, mean_us", 32'(out_if.mean_us), 0);
      end else begin
        want = pending_stats.pop_front();
        if (out_if.mean_us !== want.mean_us)
          report_mismatch("mean_us", 32'(out_if.mean_us), 32'(want.mean_us));
        if (out_if.min_us !== want.min_us)
          report_mismatch("min_us", 32'(out_if.min_us), 32'(want.min_us));
        if (out_if.max_us !== want.max_us)
          report_mismatch("max_us", 32'(out_if.max_us), 32'(want.max_us));
        if (out_if.rate_centi_fps !== want.rate_centi_fps)
          report_mismatch("rate_centi_fps", 32'(out_if.rate_centi_fps),
                          32'(want.rate_centi_fps));
      end
    end
  end

  initial begin
    rst_ni                    = 1'b0;
    in_if.valid               = 1'b0;
    in_if.frame_time_us       = '0;
    cfg_if.valid              = 1'b0;
    cfg_if.update_interval_us = '0;
    out_if.ready              = 1'b0;
    for (int unsigned i = 0; i < HIST_DEPTH; i++) win_ring[i] = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].op == ROW_INTERVAL) begin
        write_interval(dir_rows[r].value);
      end else begin
        sender_gap();
        send_frame(dir_rows[r].value, dir_rows[r].chk, dir_rows[r].typed);
      end
    end

    // Tiny frames with an update on every item drive the mean to zero and one;
    // the long hold-off at the start backs the block up into its input.
    run_phase('0, 170, STYLE_TINY, 1'b1, 1'b0);
    run_phase(DATA_W'(1), 80, STYLE_MIXED, 1'b0, 1'b0);
    run_phase(DATA_W'($urandom_range(0, 20'hFFFFF)), 200, STYLE_MIXED, 1'b0, 1'b1);
    run_phase('1, 150, STYLE_MIXED, 1'b0, 1'b0);
    run_phase(DATA_W'($urandom_range(1, 100000)), 150, STYLE_MIXED, 1'b0, 1'b0);
    idle_off = 1'b1;
    run_phase(DATA_W'(16667), 100, STYLE_STEADY, 1'b0, 1'b0);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_stats.size() != 0)
      report_mismatch("results never delivered", 0, 32'(pending_stats.size()));
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
